// File: rtl/mclcar_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the multi-channel load-cell reader.
// Used by the lane, merge, divider and top-level modules.
package mclcar_pkg;

    localparam int MAX_CH      = 4;   // converter data lines
    localparam int SAMPLE_BITS = 24;  // bits per conversion
    localparam int SUM_W       = 32;  // per-channel accumulator width
    localparam int DIV_W       = 34;  // dividend width, holds the total of all lanes
    localparam int TOTAL_W     = 26;  // averaged total width
    localparam int PULSE_W     = 5;   // pulse counter width (data bits plus gain pulses)
    localparam int CNT_W       = 8;   // averaging, timeout and read counters
    localparam int STEP_W      = 6;   // divider step counter width

    localparam logic [STEP_W-1:0]  DIV_STEPS = STEP_W'(DIV_W);
    localparam logic [PULSE_W-1:0] DATA_PULSES = PULSE_W'(SAMPLE_BITS);

    // configuration register indexes
    localparam logic [2:0] REG_ACTIVE   = 3'd0;
    localparam logic [2:0] REG_GAIN     = 3'd1;
    localparam logic [2:0] REG_AVG_CNT  = 3'd2;
    localparam logic [2:0] REG_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_PWR_DOWN = 3'd4;

    // conversion sequencer phase
    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_WAIT  = 3'b010,
        PH_SHIFT = 3'b100
    } t_phase;

    // item handling: ordinary ticks versus the final averaging pass
    typedef enum logic [2:0] {
        CTL_READY  = 3'b001,
        CTL_LAUNCH = 3'b010,
        CTL_DIVIDE = 3'b100
    } t_ctl;

    // per-lane control from the sequencer
    typedef struct packed {
        logic clr_sum;    // start of an averaged read
        logic clr_shift;  // start of a conversion
        logic shift;      // take one data bit
        logic accum;      // add finished conversion into the sum
        logic div_start;  // begin the averaging division
    } t_lane_ctl;

endpackage

// File: rtl/mclcar_div.sv
`timescale 1ns / 1ps
// Serial signed divider: DIV_W-bit dividend by an unsigned 8-bit divisor,
// one quotient bit per cycle, truncating toward zero. Uses mclcar_pkg.
module mclcar_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic signed [mclcar_pkg::DIV_W-1:0] i_dividend,
    input  logic [mclcar_pkg::CNT_W-1:0]        i_divisor,
    output logic                               o_busy,
    output logic signed [mclcar_pkg::DIV_W-1:0] o_quotient
);
    import mclcar_pkg::*;

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic              r_neg;
    logic [DIV_W-1:0]  r_mag;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;

    logic [CNT_W:0]    rem_sh;
    logic              ge;
    logic [CNT_W-1:0]  n_rem;
    logic [DIV_W-1:0]  n_mag;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_mag[DIV_W-1]};
        ge     = (rem_sh >= {1'b0, r_div});
        n_rem  = ge ? CNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[CNT_W-1:0];
        n_mag  = {r_mag[DIV_W-2:0], ge};
    end

    // control: count steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_STEPS;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != STEP_W'(1));
        end
    end

    // datapath: load magnitude, then iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIV_W-1];
            r_mag <= i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_mag <= n_mag;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule

// File: rtl/mclcar_lane.sv
`timescale 1ns / 1ps
// One converter lane: shift register, conversion accumulator and its own
// averaging divider. Uses mclcar_pkg and mclcar_div.
module mclcar_lane (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  mclcar_pkg::t_lane_ctl                    i_ctl,
    input  logic                                     i_bit,
    input  logic [mclcar_pkg::CNT_W-1:0]             i_divisor,
    output logic signed [mclcar_pkg::SUM_W-1:0]      o_sum,
    output logic signed [mclcar_pkg::SAMPLE_BITS-1:0] o_avg,
    output logic                                     o_busy
);
    import mclcar_pkg::*;

    logic [SAMPLE_BITS-1:0]  r_shift;
    logic signed [SUM_W-1:0] r_sum;
    logic [SAMPLE_BITS-1:0]  n_shift;
    logic signed [SUM_W-1:0] sample_ext;
    logic signed [DIV_W-1:0] quot;

    // next shift contents: the finished conversion includes this tick's bit
    always_comb begin
        if (i_ctl.shift) begin
            n_shift = {r_shift[SAMPLE_BITS-2:0], i_bit};
        end else begin
            n_shift = r_shift;
        end
        sample_ext = $signed({{(SUM_W-SAMPLE_BITS){n_shift[SAMPLE_BITS-1]}}, n_shift});
    end

    // shift in data, accumulate conversions
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_shift) begin
            r_shift <= '0;
        end else begin
            r_shift <= n_shift;
        end
        if (i_ctl.clr_sum) begin
            r_sum <= '0;
        end else if (i_ctl.accum) begin
            r_sum <= r_sum + sample_ext;
        end
    end

    mclcar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend ($signed({{(DIV_W-SUM_W){r_sum[SUM_W-1]}}, r_sum})),
        .i_divisor  (i_divisor),
        .o_busy     (o_busy),
        .o_quotient (quot)
    );

    assign o_sum = r_sum;
    assign o_avg = quot[SAMPLE_BITS-1:0];

endmodule

// File: rtl/mclcar_merge.sv
`timescale 1ns / 1ps
// Merge stage: adds the lane accumulators into the all-channel total and
// divides it by the averaging count. Uses mclcar_pkg and mclcar_div.
module mclcar_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [mclcar_pkg::SUM_W-1:0]  i_sums [mclcar_pkg::MAX_CH],
    input  logic [mclcar_pkg::CNT_W-1:0]         i_divisor,
    output logic signed [mclcar_pkg::TOTAL_W-1:0] o_total,
    output logic                                 o_busy
);
    import mclcar_pkg::*;

    logic signed [DIV_W-1:0] r_total;
    logic                    r_pend;
    logic signed [DIV_W-1:0] n_total;
    logic                    div_busy;
    logic signed [DIV_W-1:0] quot;

    // add all lanes; inactive lanes hold zero
    always_comb begin
        n_total = '0;
        for (int k = 0; k < MAX_CH; k++) begin
            n_total = n_total + $signed({{(DIV_W-SUM_W){i_sums[k][SUM_W-1]}}, i_sums[k]});
        end
    end

    // register the total, start the division in the cycle after
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            r_pend <= i_start;
        end
        if (i_start) begin
            r_total <= n_total;
        end
    end

    mclcar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_pend),
        .i_dividend (r_total),
        .i_divisor  (i_divisor),
        .o_busy     (div_busy),
        .o_quotient (quot)
    );

    assign o_busy  = r_pend | div_busy;
    assign o_total = quot[TOTAL_W-1:0];

endmodule

// File: rtl/multi_channel_load_cell_adc_reader.sv
`timescale 1ns / 1ps
// Reader for up to four 24-bit load-cell converters on one shared serial clock.
// Each input transfer is one clock half-period tick (or a start command) and
// yields exactly one output transfer with the clock level to drive and status.
// The tick that ends an averaged read holds the input while four lane dividers
// and the merge divider each run 34 serial steps; the merge divider starts in
// the cycle after the lanes, since it first adds the lane sums. No clearing
// pass after reset.
// Depends on mclcar_pkg, mclcar_lane, mclcar_merge.
module multi_channel_load_cell_adc_reader (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [3:0] dout_bits, [7:4] zero
    input  logic [0:0]   i_s_axis_tuser,   // [0] command
    // output stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // [0] sck_level, [1] busy_res, [2] done_res,
                                           // [3] timed_out, [27:4] avg_ch0,
                                           // [51:28] avg_ch1, [75:52] avg_ch2,
                                           // [99:76] avg_ch3, [125:100] avg_total,
                                           // [127:126] zero
    // configuration
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_wdata
);
    import mclcar_pkg::*;

    // configuration registers
    logic [2:0]       r_active;
    logic [1:0]       r_gain;
    logic [CNT_W-1:0] r_avg_cnt;
    logic [CNT_W-1:0] r_timeout;
    logic             r_pwr_down;

    // sequencer state
    t_phase           r_phase, n_phase;
    t_ctl             r_ctl;
    logic [PULSE_W-1:0] r_pulse, n_pulse;
    logic             r_clk_high, n_clk_high;
    logic [CNT_W-1:0] r_wait, n_wait;
    logic [CNT_W-1:0] r_reads, n_reads;

    // output register
    logic             r_out_valid;
    logic             r_out_sck, r_out_busy, r_out_done, r_out_tmo;
    logic signed [SAMPLE_BITS-1:0] r_out_avg [MAX_CH];
    logic signed [TOTAL_W-1:0]     r_out_total;

    // tick results and lane controls
    logic             accept, out_take;
    logic             cmd;
    logic [3:0]       dout;
    logic [2:0]       live;
    logic [3:0]       need;
    logic [CNT_W-1:0] n_count;
    logic             res_sck, res_busy, res_done, res_tmo, res_final;
    logic             c_clr_sum, c_clr_shift, c_shift, c_accum;
    logic [PULSE_W-1:0] pulse_inc;
    logic [CNT_W-1:0] wait_dec, reads_inc;
    t_lane_ctl        lane_ctl [MAX_CH];

    logic signed [SUM_W-1:0]       lane_sum [MAX_CH];
    logic signed [SUM_W-1:0]       merge_sum [MAX_CH];
    logic signed [SAMPLE_BITS-1:0] lane_avg [MAX_CH];
    logic [MAX_CH-1:0]             lane_busy;
    logic signed [TOTAL_W-1:0]     merge_total;
    logic                          merge_busy;

    assign cmd      = i_s_axis_tuser[0];
    assign dout     = i_s_axis_tdata[3:0];
    assign out_take = r_out_valid & i_m_axis_tready;
    assign o_s_axis_tready = (r_ctl == CTL_READY) && (!r_out_valid || i_m_axis_tready);
    assign accept   = i_s_axis_tvalid & o_s_axis_tready;

    // capped channel count, ready mask and effective averaging count
    always_comb begin
        live    = (r_active > 3'd4) ? 3'd4 : r_active;
        need    = 4'((5'd1 << live) - 5'd1);
        n_count = (r_avg_cnt == '0) ? CNT_W'(1) : r_avg_cnt;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 3'd4;
            r_gain     <= 2'd1;
            r_avg_cnt  <= CNT_W'(1);
            r_timeout  <= CNT_W'(255);
            r_pwr_down <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ACTIVE:   r_active   <= i_cfg_wdata[2:0];
                REG_GAIN:     r_gain     <= i_cfg_wdata[1:0];
                REG_AVG_CNT:  r_avg_cnt  <= i_cfg_wdata;
                REG_TIMEOUT:  r_timeout  <= i_cfg_wdata;
                REG_PWR_DOWN: r_pwr_down <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // one tick of the conversion sequencer
    always_comb begin
        n_phase     = r_phase;
        n_pulse     = r_pulse;
        n_clk_high  = r_clk_high;
        n_wait      = r_wait;
        n_reads     = r_reads;
        res_sck     = 1'b0;
        res_busy    = 1'b0;
        res_done    = 1'b0;
        res_tmo     = 1'b0;
        res_final   = 1'b0;
        c_clr_sum   = 1'b0;
        c_clr_shift = 1'b0;
        c_shift     = 1'b0;
        c_accum     = 1'b0;
        pulse_inc   = r_pulse + 1'b1;
        wait_dec    = r_wait - 1'b1;
        reads_inc   = r_reads + 1'b1;
        unique case (r_phase)
            PH_WAIT: begin
                if ((dout & need) == 4'd0) begin
                    n_phase     = PH_SHIFT;
                    n_pulse     = '0;
                    n_clk_high  = 1'b0;
                    c_clr_shift = 1'b1;
                    res_busy    = 1'b1;
                end else begin
                    n_wait = wait_dec;
                    if (wait_dec == '0) begin
                        n_phase  = PH_IDLE;
                        res_done = 1'b1;
                        res_tmo  = 1'b1;
                    end else begin
                        res_busy = 1'b1;
                    end
                end
            end
            PH_SHIFT: begin
                if (!r_clk_high) begin
                    res_sck    = 1'b1;
                    n_clk_high = 1'b1;
                    res_busy   = 1'b1;
                end else begin
                    n_clk_high = 1'b0;
                    c_shift    = (r_pulse < DATA_PULSES);
                    if (pulse_inc >= DATA_PULSES + {3'b000, r_gain}) begin
                        c_accum = 1'b1;
                        n_reads = reads_inc;
                        n_pulse = '0;
                        if (reads_inc >= n_count) begin
                            n_phase   = PH_IDLE;
                            res_done  = 1'b1;
                            res_final = 1'b1;
                        end else begin
                            n_phase  = PH_WAIT;
                            n_wait   = r_timeout;
                            res_busy = 1'b1;
                        end
                    end else begin
                        n_pulse  = pulse_inc;
                        res_busy = 1'b1;
                    end
                end
            end
            default: begin
                // idle: a start command opens an averaged read
                if (cmd) begin
                    n_phase     = PH_WAIT;
                    n_wait      = r_timeout;
                    n_reads     = '0;
                    n_pulse     = '0;
                    n_clk_high  = 1'b0;
                    c_clr_sum   = 1'b1;
                    c_clr_shift = 1'b1;
                    res_busy    = 1'b1;
                end else begin
                    res_sck = r_pwr_down;
                end
            end
        endcase
    end

    // advance the sequencer on each accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_pulse    <= '0;
            r_clk_high <= 1'b0;
            r_wait     <= '0;
            r_reads    <= '0;
        end else if (accept) begin
            r_phase    <= n_phase;
            r_pulse    <= n_pulse;
            r_clk_high <= n_clk_high;
            r_wait     <= n_wait;
            r_reads    <= n_reads;
        end
    end

    // lanes: gate controls by the transfer, accumulate active channels only
    for (genvar k = 0; k < MAX_CH; k++) begin : g_lane
        always_comb begin
            lane_ctl[k].clr_sum   = accept & c_clr_sum;
            lane_ctl[k].clr_shift = accept & c_clr_shift;
            lane_ctl[k].shift     = accept & c_shift;
            lane_ctl[k].accum     = accept & c_accum & (3'(k) < live);
            lane_ctl[k].div_start = (r_ctl == CTL_LAUNCH);
            // drop lanes that are inactive at the end of the read
            merge_sum[k]          = (3'(k) < live) ? lane_sum[k] : '0;
        end

        mclcar_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (lane_ctl[k]),
            .i_bit     (dout[k]),
            .i_divisor (n_count),
            .o_sum     (lane_sum[k]),
            .o_avg     (lane_avg[k]),
            .o_busy    (lane_busy[k])
        );
    end

    mclcar_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_ctl == CTL_LAUNCH),
        .i_sums    (merge_sum),
        .i_divisor (n_count),
        .o_total   (merge_total),
        .o_busy    (merge_busy)
    );

    // item control: hold input while the averages are divided
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl       <= CTL_READY;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_ctl)
                CTL_LAUNCH: begin
                    r_ctl <= CTL_DIVIDE;
                end
                CTL_DIVIDE: begin
                    if (lane_busy == '0 && !merge_busy) begin
                        r_ctl       <= CTL_READY;
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    // a final tick launches the division, any other tick loads a result
                    if (accept && res_final) begin
                        r_ctl <= CTL_LAUNCH;
                    end
                    if (accept && !res_final) begin
                        r_out_valid <= 1'b1;
                    end else if (out_take) begin
                        r_out_valid <= 1'b0;
                    end
                end
            endcase
        end
    end

    // output payload: status at the transfer, averages when division ends
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_sck   <= res_sck;
            r_out_busy  <= res_busy;
            r_out_done  <= res_done;
            r_out_tmo   <= res_tmo;
            r_out_total <= '0;
            for (int k = 0; k < MAX_CH; k++) begin
                r_out_avg[k] <= '0;
            end
        end else if (r_ctl == CTL_DIVIDE && lane_busy == '0 && !merge_busy) begin
            r_out_total <= merge_total;
            for (int k = 0; k < MAX_CH; k++) begin
                r_out_avg[k] <= (3'(k) < live) ? lane_avg[k] : '0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_out_total, r_out_avg[3], r_out_avg[2], r_out_avg[1],
                              r_out_avg[0], r_out_tmo, r_out_done, r_out_busy, r_out_sck};

endmodule

// File: rtl/mclcar_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the load-cell reader, bound to the top level.
// Sees only the top-level ports; no package needed.
module mclcar_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         o_s_axis_tready,
    input logic [7:0]   i_s_axis_tdata,
    input logic [0:0]   i_s_axis_tuser,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [127:0] o_m_axis_tdata,
    input logic         i_cfg_we,
    input logic [2:0]   i_cfg_index,
    input logic [7:0]   i_cfg_wdata
);

    // stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // a finished read is never also busy
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[1] && o_m_axis_tdata[2]))
        else $error("done and busy together");

    // timeout only reported with done, and carries no averages
    a_tmo_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |->
            o_m_axis_tdata[2] && (o_m_axis_tdata[125:4] == '0))
        else $error("bad timeout result");

    // averages stay zero on every tick without done
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[2] |-> (o_m_axis_tdata[125:4] == '0))
        else $error("averages on a tick without done");

endmodule

bind multi_channel_load_cell_adc_reader mclcar_checker u_mclcar_checker (.*);

// File: tb/sv/load_cell_reader_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the load-cell reader: tracks register writes and input ticks,
// predicts every tick result and compares it with the output stream.
// Depends on mclcar_pkg for the phase enum, register indexes and sample width.
module load_cell_reader_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [3:0] dout_bits, [7:4] zero
    input  logic [0:0]   i_s_axis_tuser,   // [0] command
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    input  logic [127:0] i_m_axis_tdata,   // [0] sck_level, [1] busy_res, [2] done_res,
                                           // [3] timed_out, [27:4] avg_ch0,
                                           // [51:28] avg_ch1, [75:52] avg_ch2,
                                           // [99:76] avg_ch3, [125:100] avg_total,
                                           // [127:126] zero
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_wdata,
    output int           o_fail_count,
    output int           o_pending,
    output logic         o_reading,
    output int           o_checked,
    output int           o_reads_done,
    output int           o_reads_timed_out
);
    import mclcar_pkg::*;

    localparam int NUM_FIELDS = 10;
    localparam int FIELD_LO [NUM_FIELDS] = '{0, 1, 2, 3, 4, 28, 52, 76, 100, 126};
    localparam int FIELD_W  [NUM_FIELDS] = '{1, 1, 1, 1, 24, 24, 24, 24, 26, 2};
    localparam int MAX_REPORTS = 40;

    string field_name [NUM_FIELDS] = '{"sck_level", "busy_res", "done_res", "timed_out",
                                       "avg_ch0", "avg_ch1", "avg_ch2", "avg_ch3",
                                       "avg_total", "padding"};

    // register copies
    logic [2:0] cfg_active;
    logic [1:0] cfg_gain;
    logic [7:0] cfg_avg;
    logic [7:0] cfg_timeout;
    logic       cfg_power_down;

    // sequencer copy
    t_phase     seq_phase;
    logic [4:0] pulse_cnt;
    logic       sck_high;
    logic [7:0] wait_cnt;
    logic [7:0] conv_cnt;
    logic [SAMPLE_BITS-1:0] shift_reg [4];
    longint     chan_acc [4];

    logic [127:0] predicted_ticks [$];
    int fails, checked, reads_done, reads_timed_out;

    // Advance the sequencer copy by one tick and return the packed result.
    function automatic logic [127:0] predict_tick(input logic cmd, input logic [3:0] dout);
        int unsigned nch, n;
        int k;
        logic [3:0] need;
        logic sck, busy, done, tmo;
        longint ch_avg [4];
        longint all, total;
        logic [127:0] r;
        nch = (cfg_active > 3'd4) ? 4 : int'(cfg_active);
        n = (cfg_avg == 8'd0) ? 1 : int'(cfg_avg);
        need = 4'((1 << nch) - 1);
        sck = 1'b0; busy = 1'b0; done = 1'b0; tmo = 1'b0;
        all = 0; total = 0;
        for (k = 0; k < 4; k++) ch_avg[k] = 0;
        case (seq_phase)
            PH_WAIT: begin
                if ((dout & need) == 4'd0) begin
                    seq_phase = PH_SHIFT;
                    pulse_cnt = '0;
                    sck_high = 1'b0;
                    for (k = 0; k < 4; k++) shift_reg[k] = '0;
                    busy = 1'b1;
                end else begin
                    wait_cnt = wait_cnt - 8'd1;
                    if (wait_cnt == 8'd0) begin
                        seq_phase = PH_IDLE;
                        done = 1'b1;
                        tmo = 1'b1;
                    end else begin
                        busy = 1'b1;
                    end
                end
            end
            PH_SHIFT: begin
                if (!sck_high) begin
                    sck = 1'b1;
                    sck_high = 1'b1;
                    busy = 1'b1;
                end else begin
                    sck_high = 1'b0;
                    // sample one bit per lane, MSB first
                    if (pulse_cnt < SAMPLE_BITS) begin
                        for (k = 0; k < 4; k++)
                            shift_reg[k] = {shift_reg[k][SAMPLE_BITS-2:0], dout[k]};
                    end
                    pulse_cnt = pulse_cnt + 5'd1;
                    if (pulse_cnt >= SAMPLE_BITS + int'(cfg_gain)) begin
                        for (k = 0; k < nch; k++)
                            chan_acc[k] += longint'(signed'(shift_reg[k]));
                        conv_cnt = conv_cnt + 8'd1;
                        pulse_cnt = '0;
                        if (conv_cnt >= n) begin
                            // averages truncate toward zero
                            for (k = 0; k < nch; k++) begin
                                all += chan_acc[k];
                                ch_avg[k] = chan_acc[k] / longint'(n);
                            end
                            total = all / longint'(n);
                            seq_phase = PH_IDLE;
                            done = 1'b1;
                        end else begin
                            seq_phase = PH_WAIT;
                            wait_cnt = cfg_timeout;
                            busy = 1'b1;
                        end
                    end else begin
                        busy = 1'b1;
                    end
                end
            end
            default: begin
                if (cmd) begin
                    seq_phase = PH_WAIT;
                    wait_cnt = cfg_timeout;
                    conv_cnt = '0;
                    pulse_cnt = '0;
                    sck_high = 1'b0;
                    for (k = 0; k < 4; k++) begin
                        chan_acc[k] = 0;
                        shift_reg[k] = '0;
                    end
                    busy = 1'b1;
                end else begin
                    seq_phase = PH_IDLE;
                    sck = cfg_power_down;
                end
            end
        endcase
        r = '0;
        r[0] = sck;
        r[1] = busy;
        r[2] = done;
        r[3] = tmo;
        for (k = 0; k < 4; k++) r[4 + 24*k +: 24] = ch_avg[k][23:0];
        r[125:100] = total[25:0];
        return r;
    endfunction

    // Watch input transfers, register writes and output transfers.
    always @(posedge i_clk) begin : monitor
        logic [127:0] want, want_f, got_f;
        int f, k;
        if (!i_rst_n) begin
            cfg_active = 3'd4;
            cfg_gain = 2'd1;
            cfg_avg = 8'd1;
            cfg_timeout = 8'd255;
            cfg_power_down = 1'b1;
            seq_phase = PH_IDLE;
            pulse_cnt = '0;
            sck_high = 1'b0;
            wait_cnt = '0;
            conv_cnt = '0;
            for (k = 0; k < 4; k++) begin
                shift_reg[k] = '0;
                chan_acc[k] = 0;
            end
            predicted_ticks.delete();
        end else begin
            // a tick at the same edge as a write still sees the old register
            if (i_s_axis_tvalid && i_s_axis_tready)
                predicted_ticks.push_back(predict_tick(i_s_axis_tuser[0], i_s_axis_tdata[3:0]));
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ACTIVE:   cfg_active = i_cfg_wdata[2:0];
                    REG_GAIN:     cfg_gain = i_cfg_wdata[1:0];
                    REG_AVG_CNT:  cfg_avg = i_cfg_wdata;
                    REG_TIMEOUT:  cfg_timeout = i_cfg_wdata;
                    REG_PWR_DOWN: cfg_power_down = i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (predicted_ticks.size() == 0) begin
                    if (fails < MAX_REPORTS)
                        $display("%0t: result with nothing expected, got %h", $time,
                                 i_m_axis_tdata);
                    fails++;
                end else begin
                    want = predicted_ticks.pop_front();
                    checked++;
                    if (want[2]) reads_done++;
                    if (want[3]) reads_timed_out++;
                    for (f = 0; f < NUM_FIELDS; f++) begin
                        want_f = (want >> FIELD_LO[f]) & ~({128{1'b1}} << FIELD_W[f]);
                        got_f = (i_m_axis_tdata >> FIELD_LO[f]) & ~({128{1'b1}} << FIELD_W[f]);
                        if (got_f !== want_f) begin
                            if (fails < MAX_REPORTS)
                                $display("%0t: %s expected %0h got %0h", $time,
                                         field_name[f], want_f, got_f);
                            fails++;
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= predicted_ticks.size();
        o_reading <= (seq_phase != PH_IDLE);
        o_checked <= checked;
        o_reads_done <= reads_done;
        o_reads_timed_out <= reads_timed_out;
    end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Top of the load-cell reader testbench: clock, reset, register settings,
// tick stimulus with random idling, and the verdict.
// Depends on mclcar_pkg, multi_channel_load_cell_adc_reader, load_cell_reader_checker.
module tb;
    import mclcar_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_LEN = 300;
    localparam int RANDOM_SETTINGS = 6;
    localparam int RANDOM_TICKS = 90;
    localparam int SND_IDLE [3] = '{37, 58, 0};
    localparam int RCV_IDLE [3] = '{58, 37, 0};

    typedef enum int {PAT_MIXED, PAT_MAXPOS, PAT_MINNEG} t_sample_pattern;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic [0:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [2:0]   cfg_index = '0;
    logic [7:0]   cfg_wdata = '0;

    int  fail_count, pending, checked, reads_done, reads_timed_out;
    logic reading;
    logic hold_req = 1'b0;

    int idle_mode = 0;
    int ticks_sent = 0;
    int settings_seen = 0;
    int sh_act = 4, sh_gain = 1, sh_avg = 1, sh_tmo = 255;

    multi_channel_load_cell_adc_reader dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    load_cell_reader_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_s_axis_tvalid   (s_tvalid),
        .i_s_axis_tready   (s_tready),
        .i_s_axis_tdata    (s_tdata),
        .i_s_axis_tuser    (s_tuser),
        .i_m_axis_tvalid   (m_tvalid),
        .i_m_axis_tready   (m_tready),
        .i_m_axis_tdata    (m_tdata),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_reading         (reading),
        .o_checked         (checked),
        .o_reads_done      (reads_done),
        .o_reads_timed_out (reads_timed_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int live_ch();
        return (sh_act > 4) ? 4 : sh_act;
    endfunction

    function automatic int eff_avg();
        return (sh_avg == 0) ? 1 : sh_avg;
    endfunction

    function automatic int eff_tmo();
        return (sh_tmo == 0) ? 256 : sh_tmo;
    endfunction

    // occasional start command while a read is running
    function automatic logic stray_start();
        return ($urandom_range(0, 9) == 0);
    endfunction

    function automatic logic [23:0] pick_sample(input t_sample_pattern pat);
        case (pat)
            PAT_MAXPOS: return 24'h7FFFFF;
            PAT_MINNEG: return 24'h800000;
            default: begin
                case ($urandom_range(0, 5))
                    0: return 24'h800000;
                    1: return 24'h7FFFFF;
                    2: return 24'h000000;
                    3: return 24'hFFFFFF;
                    default: return 24'($urandom);
                endcase
            end
        endcase
    endfunction

    // Offer one tick and hold it until the transfer.
    task automatic send_tick(input logic cmd, input logic [3:0] dout);
        while ($urandom_range(0, 99) < SND_IDLE[idle_mode]) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {4'b0000, dout};
        do @(posedge i_clk); while (!s_tready);
        ticks_sent++;
    endtask

    // Stop offering and wait for every predicted result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Bring the block back to idle: drain, then clock out any read in flight.
    task automatic settle();
        drain_results();
        while (reading) begin
            send_tick(1'b0, 4'b0000);
            drain_results();
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_config(input int act, input int gain, input int avg,
                                input int tmo, input int pd);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= REG_ACTIVE;
        cfg_wdata <= 8'(act);
        @(posedge i_clk);
        cfg_index <= REG_GAIN;
        cfg_wdata <= 8'(gain);
        @(posedge i_clk);
        cfg_index <= REG_AVG_CNT;
        cfg_wdata <= 8'(avg);
        @(posedge i_clk);
        cfg_index <= REG_TIMEOUT;
        cfg_wdata <= 8'(tmo);
        @(posedge i_clk);
        cfg_index <= REG_PWR_DOWN;
        cfg_wdata <= 8'(pd);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sh_act = act;
        sh_gain = gain;
        sh_avg = avg;
        sh_tmo = tmo;
        settings_seen++;
    endtask

    // at least one active line high
    task automatic not_ready_tick();
        send_tick(stray_start(), 4'($urandom) | (4'b0001 << $urandom_range(0, live_ch() - 1)));
    endtask

    // One conversion: some not-ready ticks, the ready tick, then the clock pulses.
    task automatic run_conversion(input t_sample_pattern pat, input int max_wait);
        int nch, waits, k, p;
        logic [3:0] need, d;
        logic [23:0] smp [4];
        nch = live_ch();
        need = 4'((1 << nch) - 1);
        waits = 0;
        if (nch > 0) begin
            waits = $urandom_range(0, max_wait);
            if (waits > eff_tmo() - 1) waits = eff_tmo() - 1;
        end
        repeat (waits) not_ready_tick();
        send_tick(stray_start(), 4'($urandom) & ~need);
        for (k = 0; k < 4; k++) smp[k] = pick_sample(pat);
        for (p = 0; p < SAMPLE_BITS + sh_gain; p++) begin
            // high half: lines are not sampled
            send_tick(stray_start(), 4'($urandom));
            for (k = 0; k < 4; k++)
                d[k] = (p < SAMPLE_BITS) ? smp[k][SAMPLE_BITS-1-p] : 1'($urandom);
            send_tick(stray_start(), d);
        end
    endtask

    task automatic run_read(input t_sample_pattern pat, input int max_wait);
        send_tick(1'b1, 4'($urandom));
        repeat (eff_avg()) run_conversion(pat, max_wait);
    endtask

    task automatic run_timeout();
        send_tick(1'b1, 4'($urandom));
        repeat (eff_tmo()) not_ready_tick();
    endtask

    // Mostly complete reads, some timeouts, the rest loose ticks and stray starts.
    task automatic random_setting(input int budget);
        int start_count, pick, act_pick, avg_pick;
        act_pick = $urandom_range(0, 9);
        avg_pick = $urandom_range(0, 9);
        write_config((act_pick == 0) ? 0 :
                     (act_pick < 8) ? $urandom_range(1, 4) : $urandom_range(5, 7),
                     $urandom_range(0, 3),
                     (avg_pick == 0) ? 0 :
                     (avg_pick == 1) ? $urandom_range(4, 6) : $urandom_range(1, 3),
                     ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 30),
                     $urandom_range(0, 1));
        start_count = ticks_sent;
        while (ticks_sent - start_count < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                run_read(PAT_MIXED, 4);
            end else if (pick < 80 && live_ch() > 0 && eff_tmo() <= 40) begin
                run_timeout();
            end else begin
                repeat ($urandom_range(1, 8))
                    send_tick($urandom_range(0, 3) == 0, 4'($urandom));
            end
            repeat ($urandom_range(0, 3)) send_tick(1'b0, 4'($urandom));
        end
    endtask

    // Receiver: random stalls, plus one long hold-off that backs up the block.
    initial begin : receiver
        int hold;
        logic held;
        hold = 0;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                hold = HOLD_LEN;
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= RCV_IDLE[idle_mode]);
            end
        end
    end

    // End the run when no transfer happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb: FAIL");
        $finish;
    end

    initial begin : stimulus
        int s;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short timeout, clock low when idle
        write_config(4, 1, 1, 3, 0);
        send_tick(1'b0, 4'b0000);
        send_tick(1'b0, 4'b1111);
        send_tick(1'b1, 4'b1111);
        send_tick(1'b1, 4'b1111);   // start while waiting
        send_tick(1'b0, 4'b1000);
        send_tick(1'b0, 4'b0001);   // counter runs out
        send_tick(1'b0, 4'b0000);
        run_read(PAT_MAXPOS, 2);

        // averaged most negative sample, no gain pulses; receiver holds off meanwhile
        write_config(4, 0, 2, 1, 1);
        hold_req = 1'b1;
        run_read(PAT_MINNEG, 0);
        run_timeout();

        // wrapped timeout and zero average count on one channel
        write_config(1, 2, 0, 0, 0);
        run_timeout();
        run_read(PAT_MIXED, 20);

        // no active channels
        write_config(0, 3, 1, 5, 1);
        run_read(PAT_MIXED, 3);
        repeat (6) send_tick(1'b0, 4'($urandom));

        // channel count above the cap
        write_config(7, 3, 2, 10, 1);
        run_read(PAT_MIXED, 9);
        run_timeout();

        for (s = 0; s < RANDOM_SETTINGS; s++) begin
            idle_mode = (s * 3) / RANDOM_SETTINGS;
            random_setting(RANDOM_TICKS / RANDOM_SETTINGS);
        end

        settle();
        repeat (40) @(posedge i_clk);
        $display("summary: %0d tick results checked, %0d averaged reads ended (%0d timed out)",
                 checked, reads_done, reads_timed_out);
        $display("summary: %0d register settings, %0d ticks sent", settings_seen, ticks_sent);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
